>>> rtl/jti_pkg.sv
package jti_pkg;

	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 48;
	localparam int DIV_STAGES  = 62;
	localparam int SQRT_STAGES = 31;

	localparam logic [CFG_IDX_W-1:0] REG_DURATION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL    = 2'd2;

	localparam logic [15:0] DURATION_RESET = 16'd1000;
	localparam logic        MODE_RESET     = 1'b0;
	localparam logic [47:0] ACCEL_RESET    = 48'd1048576;

	localparam logic MODE_CUBIC = 1'b0;
	localparam logic MODE_LSPB  = 1'b1;

	typedef struct packed {
		logic signed [31:0] start_position;
		logic signed [31:0] end_position;
		logic        [15:0] sample_index;
	} in_t;

	typedef struct packed {
		logic signed [31:0] position;
		logic               status;
		logic               last_sample;
	} out_t;

	// per-item values that ride alongside the long arithmetic stages
	typedef struct packed {
		logic signed [31:0] start;
		logic               neg;
		logic        [32:0] dabs;
		logic        [15:0] t;
		logic        [31:0] t2;
		logic        [31:0] nt2;
		logic               last;
		logic               err;
	} side_t;

	typedef enum logic [2:0] {
		BR_ACCEL  = 3'b001,
		BR_DECEL  = 3'b010,
		BR_CRUISE = 3'b100
	} branch_t;

endpackage

>>> rtl/joint_trajectory_interpolator.sv
// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_stall     jti_pkg::in_t  (start, end, sample index)
// result    out        result_valid / result_stall jti_pkg::out_t (position, status, last)
// config    in         cfg_we                      cfg_index, cfg_data
//
// One transaction enters per cycle while item_stall is low; its result passes 108
// register stages from input to output register.
// Most of these lie in the 62-stage restoring divider and the 31-stage square root.
// arst_n clears valid bits, the output skid and the configuration registers.
// A result arriving behind a stalled output parks in a one-entry skid; item_stall rises only
// once the skid holds a transaction, and the whole pipeline then holds.
module joint_trajectory_interpolator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  jti_pkg::in_t                      item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output jti_pkg::out_t                     result,
	input  logic                              cfg_we,
	input  logic [jti_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [jti_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import jti_pkg::*;

	// configuration
	logic [15:0] cfg_duration_q;
	logic        cfg_mode_q;
	logic [47:0] cfg_accel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_duration_q <= DURATION_RESET;
			cfg_mode_q     <= MODE_RESET;
			cfg_accel_q    <= ACCEL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DURATION: cfg_duration_q <= cfg_data[15:0];
				REG_MODE:     cfg_mode_q     <= cfg_data[0];
				REG_ACCEL:    cfg_accel_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Derived move constants. Each is registered and settles after a write, before
	// the first stage that reads it sees an item.
	logic [15:0] nc_q;
	logic [31:0] n2_q;
	logic [47:0] n3_q;
	logic [55:0] an2_lo_q, an2_hi_q;
	logic [79:0] an2_q;

	always_ff @(posedge clk) begin
		nc_q     <= (cfg_duration_q == 16'd0) ? 16'd1 : cfg_duration_q;
		n2_q     <= 32'(nc_q) * 32'(nc_q);
		n3_q     <= 48'(n2_q) * 48'(nc_q);
		an2_lo_q <= 56'(cfg_accel_q[23:0]) * 56'(n2_q);
		an2_hi_q <= 56'(cfg_accel_q[47:24]) * 56'(n2_q);
		an2_q    <= 80'(an2_lo_q) + {an2_hi_q, 24'd0};
	end

	// flow control: hold every pipeline stage while the skid is occupied
	logic en;
	logic out_v_q, sk_v_q;
	out_t out_q, sk_q;

	assign en         = !sk_v_q;
	assign item_stall = sk_v_q;

	// stage 1: register the transaction
	logic v_s1;
	in_t  item_s1;

	// stage 2: displacement and clamped index
	logic               v_s2;
	logic signed [31:0] start_s2;
	logic               neg_s2, last_s2;
	logic        [32:0] dabs_s2;
	logic        [15:0] t_s2;

	logic [32:0] dif;
	logic [15:0] n_raw, t_cl;

	assign dif   = {item_s1.end_position[31], item_s1.end_position}
	             - {item_s1.start_position[31], item_s1.start_position};
	assign n_raw = (cfg_duration_q == 16'd0) ? 16'd1 : cfg_duration_q;
	assign t_cl  = (item_s1.sample_index > n_raw) ? n_raw : item_s1.sample_index;

	// stage 3: t^2, 3N-2t, N-t
	logic               v_s3;
	logic signed [31:0] start_s3;
	logic               neg_s3, last_s3;
	logic        [32:0] dabs_s3;
	logic        [15:0] t_s3, nt_s3;
	logic        [31:0] t2_s3;
	logic        [17:0] k3_s3;

	// stage 4: cubic shape f = t^2 (3N-2t), (N-t)^2
	logic        v_s4;
	side_t       side_s4;
	logic [47:0] f_s4;
	logic [49:0] f_full;

	assign f_full = 50'(t2_s3) * 50'(k3_s3);

	// stage 5: D * f in two halves
	logic        v_s5;
	side_t       side_s5;
	logic [56:0] pl_s5, ph_s5;

	// stage 6: dividend and LSPB feasibility
	logic        v_s6;
	side_t       side_s6;
	logic [88:0] x_s6;
	logic [80:0] cub_num;
	side_t       side_d6;

	assign cub_num = 81'(pl_s5) + {ph_s5, 24'd0} + 81'(n3_q[47:1]);

	always_comb begin
		side_d6     = side_s5;
		// too small when a N^2 falls short of D scaled to Q.26
		side_d6.err = (cfg_mode_q == MODE_LSPB) && (an2_q < 80'({side_s5.dabs, 26'd0}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1  <= item;

			start_s2 <= item_s1.start_position;
			neg_s2   <= dif[32];
			dabs_s2  <= dif[32] ? (~dif + 33'd1) : dif;
			t_s2     <= t_cl;
			last_s2  <= (t_cl == n_raw);

			start_s3 <= start_s2;
			neg_s3   <= neg_s2;
			last_s3  <= last_s2;
			dabs_s3  <= dabs_s2;
			t_s3     <= t_s2;
			nt_s3    <= nc_q - t_s2;
			t2_s3    <= 32'(t_s2) * 32'(t_s2);
			k3_s3    <= 18'(nc_q) * 18'd3 - {1'b0, t_s2, 1'b0};

			side_s4.start <= start_s3;
			side_s4.neg   <= neg_s3;
			side_s4.dabs  <= dabs_s3;
			side_s4.t     <= t_s3;
			side_s4.t2    <= t2_s3;
			side_s4.nt2   <= 32'(nt_s3) * 32'(nt_s3);
			side_s4.last  <= last_s3;
			side_s4.err   <= 1'b0;
			f_s4          <= f_full[47:0];

			side_s5 <= side_s4;
			pl_s5   <= 57'(side_s4.dabs) * 57'(f_s4[23:0]);
			ph_s5   <= 57'(side_s4.dabs) * 57'(f_s4[47:24]);

			side_s6 <= side_d6;
			x_s6    <= (cfg_mode_q == MODE_LSPB) ? {side_s5.dabs, 56'd0} : 89'(cub_num);
		end
	end

	// Restoring divider, one quotient bit per stage. Cubic divides by N^3,
	// LSPB divides D 2^56 by the acceleration.
	logic [47:0] div_y;
	logic        dv_v_s    [DIV_STAGES];
	logic [47:0] dv_rem_s  [DIV_STAGES];
	logic [61:0] dv_qx_s   [DIV_STAGES];
	side_t       dv_side_s [DIV_STAGES];

	assign div_y = (cfg_mode_q == MODE_LSPB) ? cfg_accel_q : n3_q;

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		logic        v_in;
		logic [47:0] rem_in;
		logic [61:0] qx_in;
		side_t       side_in;
		logic [48:0] trial, diff;

		if (i == 0) begin : g_first
			assign v_in    = v_s6;
			assign rem_in  = 48'(x_s6[88:62]);
			assign qx_in   = x_s6[61:0];
			assign side_in = side_s6;
		end else begin : g_next
			assign v_in    = dv_v_s[i-1];
			assign rem_in  = dv_rem_s[i-1];
			assign qx_in   = dv_qx_s[i-1];
			assign side_in = dv_side_s[i-1];
		end

		assign trial = {rem_in, qx_in[61]};
		assign diff  = trial - {1'b0, div_y};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[i] <= 1'b0;
			end else if (en) begin
				dv_v_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_side_s[i] <= side_in;
				if (trial >= {1'b0, div_y}) begin
					dv_rem_s[i] <= diff[47:0];
					dv_qx_s[i]  <= {qx_in[60:0], 1'b1};
				end else begin
					dv_rem_s[i] <= trial[47:0];
					dv_qx_s[i]  <= {qx_in[60:0], 1'b0};
				end
			end
		end
	end

	// stage 7: radicand N^2 2^30 - |d|/a
	logic        v_s7;
	side_t       side_s7;
	logic [61:0] r_s7;
	logic [32:0] qc_s7;
	logic [61:0] quot, top;

	assign quot = dv_qx_s[DIV_STAGES-1];
	assign top  = {n2_q, 30'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= dv_v_s[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s7 <= dv_side_s[DIV_STAGES-1];
			r_s7    <= (quot < top) ? (top - quot) : 62'd0;
			qc_s7   <= quot[32:0];
		end
	end

	// integer square root, one root bit per stage
	logic        sq_v_s    [SQRT_STAGES];
	logic [32:0] sq_rem_s  [SQRT_STAGES];
	logic [30:0] sq_root_s [SQRT_STAGES];
	logic [61:0] sq_x_s    [SQRT_STAGES];
	side_t       sq_side_s [SQRT_STAGES];
	logic [32:0] sq_qc_s   [SQRT_STAGES];

	for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_sqrt
		logic        v_in;
		logic [32:0] rem_in, qc_in;
		logic [30:0] root_in;
		logic [61:0] x_in;
		side_t       side_in;
		logic [34:0] cur, trial;

		if (i == 0) begin : g_first
			assign v_in    = v_s7;
			assign rem_in  = 33'd0;
			assign root_in = 31'd0;
			assign x_in    = r_s7;
			assign side_in = side_s7;
			assign qc_in   = qc_s7;
		end else begin : g_next
			assign v_in    = sq_v_s[i-1];
			assign rem_in  = sq_rem_s[i-1];
			assign root_in = sq_root_s[i-1];
			assign x_in    = sq_x_s[i-1];
			assign side_in = sq_side_s[i-1];
			assign qc_in   = sq_qc_s[i-1];
		end

		assign cur   = {rem_in, x_in[61:60]};
		assign trial = {2'b00, root_in, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[i] <= 1'b0;
			end else if (en) begin
				sq_v_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_x_s[i]    <= {x_in[59:0], 2'b00};
				sq_side_s[i] <= side_in;
				sq_qc_s[i]   <= qc_in;
				if (cur >= trial) begin
					sq_rem_s[i]  <= 33'(cur - trial);
					sq_root_s[i] <= {root_in[29:0], 1'b1};
				end else begin
					sq_rem_s[i]  <= cur[32:0];
					sq_root_s[i] <= {root_in[29:0], 1'b0};
				end
			end
		end
	end

	// stage 8: blend time tb, Q.16 samples
	logic        v_s8;
	side_t       side_s8;
	logic [32:0] qc_s8;
	logic [30:0] tb_s8;

	// stage 9: pick the segment and the multiplier operand
	logic        v_s9;
	side_t       side_s9;
	logic [32:0] qc_s9;
	logic [31:0] m_s9;
	branch_t     br_s9;
	logic        up_s9;
	logic [16:0] k_s9;

	logic [15:0] nt9;
	logic        c_acc, c_dec, up9;
	logic [16:0] t2x, nx;

	assign nt9   = nc_q - side_s8.t;
	assign c_acc = {side_s8.t, 16'd0} <= {1'b0, tb_s8};
	assign c_dec = {nt9, 16'd0} <= {1'b0, tb_s8};
	assign t2x   = {side_s8.t, 1'b0};
	assign nx    = {1'b0, nc_q};
	assign up9   = (t2x >= nx);

	// stage 10: a * m in two halves
	logic        v_s10;
	side_t       side_s10;
	logic [32:0] qc_s10;
	logic [55:0] pl_s10, ph_s10;
	branch_t     br_s10;
	logic        up_s10;
	logic [16:0] k_s10;

	// stage 11: round and scale; v for the cruise segment
	logic        v_s11;
	side_t       side_s11;
	logic [32:0] qc_s11;
	logic [63:0] w_s11;
	branch_t     br_s11;
	logic        up_s11;
	logic [16:0] k_s11;

	logic [80:0] am_sum;

	assign am_sum = 81'(pl_s10) + {1'b0, ph_s10, 24'd0}
	              + ((br_s10 == BR_CRUISE) ? 81'd32768 : 81'd16777216);

	// stage 12: blend offsets; v |2t-N| in two halves
	logic        v_s12;
	side_t       side_s12;
	logic [32:0] qc_s12, u_s12;
	logic [48:0] pvl_s12;
	logic [47:0] pvh_s12;
	branch_t     br_s12;
	logic        up_s12;

	logic [32:0] u_blend;

	always_comb begin
		u_blend = 33'd0;
		case (br_s11)
			BR_ACCEL: u_blend = (w_s11 > 64'(side_s11.dabs)) ? side_s11.dabs : w_s11[32:0];
			BR_DECEL: u_blend = (w_s11 > 64'(side_s11.dabs)) ? 33'd0
			                  : (side_s11.dabs - w_s11[32:0]);
			default:  u_blend = 33'd0;
		endcase
	end

	// stage 13: rounded cruise term p
	logic        v_s13;
	side_t       side_s13;
	logic [32:0] qc_s13, u_s13;
	logic [56:0] p_s13;
	branch_t     br_s13;
	logic        up_s13;

	logic [80:0] psum;

	assign psum = 81'(pvl_s12) + {1'b0, pvh_s12, 32'd0} + 81'd8388608;

	// stage 14: final offset
	logic               v_s14;
	logic signed [31:0] start_s14;
	logic               neg_s14, err_s14, last_s14;
	logic        [32:0] u_s14;

	logic [33:0] d2, p2;
	logic [32:0] pd, u_sel, u_fin;
	logic [34:0] u2;
	logic [33:0] u3;

	always_comb begin
		d2    = {side_s13.dabs, 1'b0};
		p2    = (p_s13 > 57'(d2)) ? d2 : p_s13[33:0];
		pd    = (p2 > 34'(side_s13.dabs)) ? side_s13.dabs : p2[32:0];
		u2    = up_s13 ? (35'(side_s13.dabs) + 35'(p2)) : 35'(side_s13.dabs - pd);
		u3    = 34'((u2 + 35'd1) >> 1);
		u_sel = (br_s13 == BR_CRUISE) ? ((u3 > 34'(side_s13.dabs)) ? side_s13.dabs : u3[32:0])
		                              : u_s13;
		if (cfg_mode_q == MODE_CUBIC) begin
			u_sel = qc_s13;
		end
		u_fin = (u_sel > side_s13.dabs) ? side_s13.dabs : u_sel;
		// drop the offset when the blend cannot reach the goal
		if (side_s13.err) begin
			u_fin = 33'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
		end else if (en) begin
			v_s8  <= sq_v_s[SQRT_STAGES-1];
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s8 <= sq_side_s[SQRT_STAGES-1];
			qc_s8   <= sq_qc_s[SQRT_STAGES-1];
			tb_s8   <= {nc_q, 15'd0} - sq_root_s[SQRT_STAGES-1];

			side_s9 <= side_s8;
			qc_s9   <= qc_s8;
			up_s9   <= up9;
			k_s9    <= up9 ? (t2x - nx) : (nx - t2x);
			if (c_acc) begin
				br_s9 <= BR_ACCEL;
				m_s9  <= side_s8.t2;
			end else if (c_dec) begin
				br_s9 <= BR_DECEL;
				m_s9  <= side_s8.nt2;
			end else begin
				br_s9 <= BR_CRUISE;
				m_s9  <= 32'(tb_s8);
			end

			side_s10 <= side_s9;
			qc_s10   <= qc_s9;
			br_s10   <= br_s9;
			up_s10   <= up_s9;
			k_s10    <= k_s9;
			pl_s10   <= 56'(cfg_accel_q[23:0]) * 56'(m_s9);
			ph_s10   <= 56'(cfg_accel_q[47:24]) * 56'(m_s9);

			side_s11 <= side_s10;
			qc_s11   <= qc_s10;
			br_s11   <= br_s10;
			up_s11   <= up_s10;
			k_s11    <= k_s10;
			w_s11    <= (br_s10 == BR_CRUISE) ? am_sum[79:16] : 64'(am_sum[80:25]);

			side_s12 <= side_s11;
			qc_s12   <= qc_s11;
			br_s12   <= br_s11;
			up_s12   <= up_s11;
			u_s12    <= u_blend;
			pvl_s12  <= 49'(w_s11[31:0]) * 49'(k_s11);
			pvh_s12  <= 48'(w_s11[62:32]) * 48'(k_s11);

			side_s13 <= side_s12;
			qc_s13   <= qc_s12;
			br_s13   <= br_s12;
			up_s13   <= up_s12;
			u_s13    <= u_s12;
			p_s13    <= psum[80:24];

			start_s14 <= side_s13.start;
			neg_s14   <= side_s13.neg;
			err_s14   <= side_s13.err;
			last_s14  <= side_s13.last;
			u_s14     <= u_fin;
		end
	end

	// output register and skid
	out_t res;
	logic push, pop;

	assign res.position    = neg_s14 ? (start_s14 - signed'(u_s14[31:0]))
	                                 : (start_s14 + signed'(u_s14[31:0]));
	assign res.status      = err_s14;
	assign res.last_sample = last_s14;

	assign push = en && v_s14;
	assign pop  = out_v_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (sk_v_q) begin
			if (pop) begin
				sk_v_q <= 1'b0;
			end
		end else if (push) begin
			if (out_v_q && !pop) begin
				sk_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_v_q) begin
			if (pop) begin
				out_q <= sk_q;
			end
		end else if (push) begin
			if (out_v_q && !pop) begin
				sk_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

endmodule

>>> rtl/jti_checker.sv
module jti_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          item_stall,
	input logic          result_valid,
	input logic          result_stall,
	input jti_pkg::out_t result
);

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result changed while stalled");

	// the skid only fills behind an occupied output
	a_skid_behind: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("skid occupied with empty output");

	a_skid_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(item_stall) |-> $past(result_valid && result_stall))
		else $error("input stalled without a stalled result");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall && !result_stall |=> !item_stall)
		else $error("skid not drained after result taken");

endmodule

bind joint_trajectory_interpolator jti_checker u_jti_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
